/* design/tcw_pkg.sv */
package tcw_pkg;

    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int FUNC_W = 3;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;

    // Configuration register indexes.
    localparam logic [0:0] REG_DEFAULT_ATTR = 1'd0;
    localparam logic [0:0] REG_ERROR_ATTR   = 1'd1;

    localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [BYTE_W-1:0] ERROR_ATTR_RST   = 8'd244;

    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ERROR     = 8'h45;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT_CUR = 3'd0,
        FN_PUT_AT  = 3'd1,
        FN_BKSP    = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_READ    = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        S_BLANK,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_DONE
    } t_state;

    // What one operation does to the cell store and the cursor.
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [CELL_W-1:0] cell_word;
        logic [ROW_W-1:0]  tgt_row;
        logic [COL_W-1:0]  tgt_col;
        logic              move;
        logic [ROW_W-1:0]  new_row;
        logic [COL_W-1:0]  new_col;
        logic              scroll;
        logic              clear;
        logic              oor;
    } t_plan;

endpackage

/* design/tcw_plan_decode.sv */
module tcw_plan_decode #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic [tcw_pkg::FUNC_W-1:0] i_func,
    input  logic [tcw_pkg::BYTE_W-1:0] i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]  i_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_col,
    input  logic [tcw_pkg::BYTE_W-1:0] i_attr,
    input  logic [tcw_pkg::ROW_W-1:0]  i_cur_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_cur_col,
    input  logic [tcw_pkg::BYTE_W-1:0] i_default_attr,
    input  logic [tcw_pkg::BYTE_W-1:0] i_error_attr,
    output tcw_pkg::t_plan             o_plan
);
    import tcw_pkg::*;

    localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]   COL_LIM  = (COL_W + 1)'(COLS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);

    logic [ROW_W-1:0]  base_row;
    logic [COL_W-1:0]  base_col;
    logic [BYTE_W-1:0] put_attr;
    logic              oor_hit;

    always_comb begin
        base_row = (i_func == FN_PUT_AT) ? i_row : i_cur_row;
        base_col = (i_func == FN_PUT_AT) ? i_col : i_cur_col;
        put_attr = (i_attr != '0) ? i_attr : i_default_attr;
        oor_hit  = (i_func inside {FN_PUT_AT, FN_READ}) &&
                   (({1'b0, i_row} >= ROW_LIM) || ({1'b0, i_col} >= COL_LIM));

        o_plan         = '0;
        o_plan.tgt_row = base_row;
        o_plan.tgt_col = base_col;
        o_plan.new_row = base_row;
        o_plan.new_col = base_col;

        if (oor_hit) begin
            o_plan.wr        = 1'b1;
            o_plan.tgt_row   = LAST_ROW;
            o_plan.tgt_col   = LAST_COL;
            o_plan.cell_word = {i_error_attr, CH_ERROR};
            o_plan.oor       = 1'b1;
        end else begin
            case (i_func)
                FN_PUT_CUR, FN_PUT_AT: begin
                    o_plan.move = 1'b1;
                    if (i_char_code == CH_BACKSPACE) begin
                        o_plan.wr        = 1'b1;
                        o_plan.cell_word = {put_attr, CH_SPACE};
                    end else begin
                        if (i_char_code != CH_NEWLINE) begin
                            o_plan.wr        = 1'b1;
                            o_plan.cell_word = {put_attr, i_char_code};
                        end
                        // A newline, or a character in the last column, wraps.
                        if (i_char_code == CH_NEWLINE || base_col == LAST_COL) begin
                            o_plan.new_col = '0;
                            if (base_row == LAST_ROW) begin
                                o_plan.scroll = 1'b1;
                            end else begin
                                o_plan.new_row = base_row + 1'b1;
                            end
                        end else begin
                            o_plan.new_col = base_col + 1'b1;
                        end
                    end
                end
                FN_BKSP: begin
                    o_plan.move      = 1'b1;
                    o_plan.wr        = 1'b1;
                    o_plan.cell_word = {i_default_attr, CH_SPACE};
                    if (i_cur_row == '0 && i_cur_col == '0) begin
                        o_plan.new_row = '0;
                        o_plan.new_col = '0;
                    end else if (i_cur_col == '0) begin
                        o_plan.new_row = i_cur_row - 1'b1;
                        o_plan.new_col = LAST_COL;
                    end else begin
                        o_plan.new_row = i_cur_row;
                        o_plan.new_col = i_cur_col - 1'b1;
                    end
                    o_plan.tgt_row = o_plan.new_row;
                    o_plan.tgt_col = o_plan.new_col;
                end
                FN_CLEAR: begin
                    o_plan.move    = 1'b1;
                    o_plan.clear   = 1'b1;
                    o_plan.new_row = '0;
                    o_plan.new_col = '0;
                end
                FN_READ: begin
                    o_plan.rd      = 1'b1;
                    o_plan.tgt_row = i_row;
                    o_plan.tgt_col = i_col;
                end
                default: begin
                    o_plan.move = 1'b0;
                end
            endcase
        end
    end

endmodule

/* design/text_console_writer.sv */
// Character-cell console of ROWS x COLS cells ({attribute, character} per cell) and a
// cursor; the cells are kept in one single-port-per-direction synchronous RAM and the
// cursor in registers. After reset the block blanks every cell, one per cycle, before it
// accepts its first item; configuration writes are taken meanwhile. Each item's result
// is registered so the next item can enter while it waits. A scroll also copies the rows
// up, one cell per cycle, and then blanks the last row; a clear also blanks every cell,
// since the RAM takes one write per cycle.
module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [tcw_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0] i_func,
    input  logic [tcw_pkg::BYTE_W-1:0] i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]  i_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_col,
    input  logic [tcw_pkg::BYTE_W-1:0] i_attr,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]  o_cursor_col,
    output logic [tcw_pkg::BYTE_W-1:0] o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0] o_cell_attr,
    output logic                       o_scrolled,
    output logic                       o_out_of_range
);
    import tcw_pkg::*;

    localparam int NCELLS = ROWS * COLS;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CNT_W  = $clog2(NCELLS + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NCELLS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCELLS - 1);
    localparam logic [CNT_W-1:0] CNT_COLS = CNT_W'(COLS);

    t_state r_state, n_state;
    logic   r_init, n_init;
    logic [CNT_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_wptr, n_wptr;
    logic   r_rvld, n_rvld;
    logic [ROW_W-1:0] r_crow, n_crow;
    logic [COL_W-1:0] r_ccol, n_ccol;
    logic   r_scr, n_scr;
    logic   r_oor, n_oor;
    logic   r_rd, n_rd;
    logic [BYTE_W-1:0] r_def_attr, r_err_attr;

    logic [FUNC_W-1:0] r_func;
    logic [BYTE_W-1:0] r_char_code;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [BYTE_W-1:0] r_attr;

    logic [CELL_W-1:0] r_mem [NCELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr, plan_addr;
    logic [CELL_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] fill_attr;

    logic   out_load;
    logic   in_acc;
    t_plan  plan;

    tcw_plan_decode #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_decode (
        .i_func         (r_func),
        .i_char_code    (r_char_code),
        .i_row          (r_row),
        .i_col          (r_col),
        .i_attr         (r_attr),
        .i_cur_row      (r_crow),
        .i_cur_col      (r_ccol),
        .i_default_attr (r_def_attr),
        .i_error_attr   (r_err_attr),
        .o_plan         (plan)
    );

    assign plan_addr  = ADDR_W'(int'(plan.tgt_row) * COLS + int'(plan.tgt_col));
    // The blanking after reset uses the reset attribute, whatever is configured meanwhile.
    assign fill_attr  = r_init ? DEFAULT_ATTR_RST : r_def_attr;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state   = r_state;
        n_init    = r_init;
        n_rptr    = r_rptr;
        n_wptr    = r_wptr;
        n_rvld    = r_rvld;
        n_crow    = r_crow;
        n_ccol    = r_ccol;
        n_scr     = r_scr;
        n_oor     = r_oor;
        n_rd      = r_rd;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = plan_addr;
        mem_raddr = plan_addr;
        mem_wdata = plan.cell_word;
        out_load  = 1'b0;

        case (r_state)
            S_BLANK: begin
                mem_we    = 1'b1;
                mem_waddr = r_wptr[ADDR_W-1:0];
                mem_wdata = {fill_attr, CH_SPACE};
                n_wptr    = r_wptr + 1'b1;
                if (r_wptr == CNT_LAST) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                mem_we = plan.wr;
                mem_re = plan.rd;
                n_scr  = plan.scroll;
                n_oor  = plan.oor;
                n_rd   = plan.rd;
                if (plan.move) begin
                    n_crow = plan.new_row;
                    n_ccol = plan.new_col;
                end
                if (plan.clear) begin
                    n_wptr  = '0;
                    n_state = S_BLANK;
                end else if (plan.scroll) begin
                    n_rptr  = CNT_COLS;
                    n_wptr  = '0;
                    n_rvld  = 1'b0;
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                // Read one row ahead, write the word back one row up in the next cycle.
                mem_re    = (r_rptr != CNT_END);
                mem_raddr = r_rptr[ADDR_W-1:0];
                n_rvld    = mem_re;
                if (mem_re) begin
                    n_rptr = r_rptr + 1'b1;
                end
                mem_we    = r_rvld;
                mem_waddr = r_wptr[ADDR_W-1:0];
                mem_wdata = r_rdata;
                if (r_rvld) begin
                    n_wptr = r_wptr + 1'b1;
                end
                // The write pointer then sits at the first cell of the last row.
                if (r_rvld && r_rptr == CNT_END) begin
                    n_state = S_BLANK;
                end
            end
            S_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_BLANK;
            r_init     <= 1'b1;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_rvld     <= 1'b0;
            r_crow     <= '0;
            r_ccol     <= '0;
            r_scr      <= 1'b0;
            r_oor      <= 1'b0;
            r_rd       <= 1'b0;
            r_def_attr <= DEFAULT_ATTR_RST;
            r_err_attr <= ERROR_ATTR_RST;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_rptr  <= n_rptr;
            r_wptr  <= n_wptr;
            r_rvld  <= n_rvld;
            r_crow  <= n_crow;
            r_ccol  <= n_ccol;
            r_scr   <= n_scr;
            r_oor   <= n_oor;
            r_rd    <= n_rd;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DEFAULT_ATTR: r_def_attr <= i_cfg_data;
                    REG_ERROR_ATTR:   r_err_attr <= i_cfg_data;
                    default:          r_def_attr <= r_def_attr;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func      <= i_func;
            r_char_code <= i_char_code;
            r_row       <= i_row;
            r_col       <= i_col;
            r_attr      <= i_attr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Result register: holds a beat until it is taken, while the next item goes on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_cursor_row   <= r_crow;
            o_cursor_col   <= r_ccol;
            o_cell_char    <= r_rd ? r_rdata[BYTE_W-1:0] : '0;
            o_cell_attr    <= r_rd ? r_rdata[CELL_W-1:BYTE_W] : '0;
            o_scrolled     <= r_scr;
            o_out_of_range <= r_oor;
        end
    end

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_in_ready)
        else $error("item accepted before the store was blanked");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_crow) < ROWS) && (int'(r_ccol) < COLS))
        else $error("cursor outside the screen");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |->
        (o_cursor_row == ROW_W'(ROWS - 1)) && (o_cursor_col == '0))
        else $error("scroll did not leave the cursor at the start of the last row");

    a_scroll_excl_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_scrolled && o_out_of_range))
        else $error("scroll reported together with an out-of-range position");

endmodule

/* sim/tb_text_console_writer.sv */
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int ROWS   = ROWS_DEF;
    localparam int COLS   = COLS_DEF;
    localparam int NCELLS = ROWS * COLS;

    // Codes the block must treat as no operation.
    localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

    localparam int N_PHASES        = 6;
    localparam int RAND_PER_PHASE  = 280;
    localparam int MAX_GAP         = 13;
    localparam int SETTLE_CYCLES   = 2 * NCELLS + 16;
    localparam int WATCHDOG_LIMIT  = 50000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [BYTE_W-1:0] attr;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0]  crow;
        logic [COL_W-1:0]  ccol;
        logic [BYTE_W-1:0] cchar;
        logic [BYTE_W-1:0] cattr;
        logic              scr;
        logic              oor;
    } t_view;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [0:0]        i_cfg_idx   = REG_DEFAULT_ATTR;
    logic [BYTE_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [BYTE_W-1:0] i_char_code = '0;
    logic [ROW_W-1:0]  i_row       = '0;
    logic [COL_W-1:0]  i_col       = '0;
    logic [BYTE_W-1:0] i_attr      = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [ROW_W-1:0]  o_cursor_row;
    logic [COL_W-1:0]  o_cursor_col;
    logic [BYTE_W-1:0] o_cell_char;
    logic [BYTE_W-1:0] o_cell_attr;
    logic              o_scrolled;
    logic              o_out_of_range;

    text_console_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_char_code    (i_char_code),
        .i_row          (i_row),
        .i_col          (i_col),
        .i_attr         (i_attr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cursor_row   (o_cursor_row),
        .o_cursor_col   (o_cursor_col),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr),
        .o_scrolled     (o_scrolled),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the screen, cursor and attribute registers.
    logic [CELL_W-1:0] screen [0:NCELLS-1];
    int unsigned       cur_pos;
    logic [BYTE_W-1:0] dflt_attr;
    logic [BYTE_W-1:0] err_attr;

    t_cmd  pending_cmds[$];
    t_view expected_views[$];
    t_cmd  cur_cmd;
    int    n_fail;
    int    n_results;
    int    snd_hold;
    int    rcv_hold;
    bit    snd_calm;
    bit    rcv_calm;
    int    idle_cycles;

    function automatic void wipe_screen();
        int i;
        for (i = 0; i < NCELLS; i++) screen[i] = {dflt_attr, CH_SPACE};
    endfunction

    // Applies one character (a newline writes nothing) at a linear position and moves the cursor; returns 1 on scroll.
    function automatic bit write_glyph(int unsigned pos, logic [BYTE_W-1:0] ch,
                                       logic [BYTE_W-1:0] at);
        logic [BYTE_W-1:0] a;
        int unsigned       p;
        int                i;
        bit                rolled;
        a = (at != '0) ? at : dflt_attr;
        p = pos;
        rolled = 1'b0;
        if (ch == CH_NEWLINE) begin
            p = (p / COLS + 1) * COLS;
        end else if (ch == CH_BACKSPACE) begin
            screen[p] = {a, CH_SPACE};
        end else begin
            screen[p] = {a, ch};
            p++;
        end
        if (p >= NCELLS) begin
            for (i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (i = NCELLS - COLS; i < NCELLS; i++) screen[i] = {dflt_attr, CH_SPACE};
            p -= COLS;
            rolled = 1'b1;
        end
        cur_pos = p;
        return rolled;
    endfunction

    function automatic t_view console_step(t_cmd c);
        t_view       v;
        int unsigned tgt;
        v = '0;
        tgt = c.row * COLS + c.col;
        if ((c.func == FN_PUT_AT || c.func == FN_READ) && (c.row >= ROWS || c.col >= COLS)) begin
            screen[NCELLS-1] = {err_attr, CH_ERROR};
            v.oor = 1'b1;
        end else begin
            case (c.func)
                FN_PUT_CUR: v.scr = write_glyph(cur_pos, c.ch, c.attr);
                FN_PUT_AT:  v.scr = write_glyph(tgt, c.ch, c.attr);
                FN_BKSP:    void'(write_glyph((cur_pos != 0) ? cur_pos - 1 : 0,
                                              CH_BACKSPACE, dflt_attr));
                FN_CLEAR: begin
                    wipe_screen();
                    cur_pos = 0;
                end
                FN_READ:    {v.cattr, v.cchar} = screen[tgt];
                default:    ;
            endcase
        end
        v.crow = ROW_W'(cur_pos / COLS);
        v.ccol = COL_W'(cur_pos % COLS);
        return v;
    endfunction

    function automatic t_cmd cmd(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] ch,
                                 logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                 logic [BYTE_W-1:0] a);
        t_cmd x;
        x.func = f;
        x.ch   = ch;
        x.row  = r;
        x.col  = c;
        x.attr = a;
        return x;
    endfunction

    // Mostly text runs and cell accesses, with the cursor pulled to the last row often
    // enough that scrolling happens regularly.
    function automatic t_cmd rand_cmd();
        t_cmd        c;
        int unsigned pick;
        pick   = $urandom_range(0, 99);
        c.ch   = BYTE_W'($urandom);
        c.attr = ($urandom_range(0, 3) == 0) ? '0 : BYTE_W'($urandom);
        c.row  = ($urandom_range(0, 4) == 0) ? ROW_W'(ROWS - 1)
                                             : ROW_W'($urandom_range(0, ROWS - 1));
        c.col  = COL_W'($urandom_range(0, COLS - 1));
        if ($urandom_range(0, 9) == 0) c.ch = CH_NEWLINE;
        else if ($urandom_range(0, 29) == 0) c.ch = CH_BACKSPACE;
        if (pick < 42) begin
            c.func = FN_PUT_CUR;
        end else if (pick < 60) begin
            c.func = FN_PUT_AT;
            if ($urandom_range(0, 9) == 0) c.col = COL_W'(COLS - 1);
        end else if (pick < 70) begin
            c.func = FN_BKSP;
        end else if (pick < 71) begin
            c.func = FN_CLEAR;
        end else if (pick < 96) begin
            c.func = FN_READ;
        end else begin
            c.func = FN_RSVD5 + FUNC_W'($urandom_range(0, 2));
        end
        if ((c.func == FN_PUT_AT || c.func == FN_READ) && $urandom_range(0, 9) == 0) begin
            c.row = ROW_W'($urandom);
            c.col = COL_W'($urandom);
        end
        return c;
    endfunction

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic log_failure(string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS) $display("%s", msg);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_DEFAULT_ATTR) dflt_attr = val;
        else err_attr = val;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_in_valid || expected_views.size() != 0)
            @(negedge i_clk);
    endtask

    // Sender: one beat per popped command, with a drawn gap after each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            snd_hold = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_views.push_back(console_step(cur_cmd));
                snd_hold = draw_gap(snd_calm);
            end
            if (!i_in_valid || o_in_ready) begin
                if (snd_hold == 0 && pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_in_valid  <= 1'b1;
                    i_func      <= cur_cmd.func;
                    i_char_code <= cur_cmd.ch;
                    i_row       <= cur_cmd.row;
                    i_col       <= cur_cmd.col;
                    i_attr      <= cur_cmd.attr;
                end else begin
                    if (snd_hold != 0) snd_hold--;
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat against the oldest prediction, then stalls for a drawn gap, which may be zero.
    always @(posedge i_clk) begin
        t_view got;
        t_view want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rcv_hold = 0;
        end else if (i_out_ready) begin
            if (o_out_valid) begin
                got = {o_cursor_row, o_cursor_col, o_cell_char, o_cell_attr,
                       o_scrolled, o_out_of_range};
                n_results++;
                if (expected_views.size() == 0) begin
                    log_failure($sformatf("result %0d arrived with nothing expected", n_results));
                end else begin
                    want = expected_views.pop_front();
                    if (got !== want)
                        log_failure($sformatf({"result %0d mismatch: expected cur %0d,%0d ",
                            "char %h attr %h scr %b oor %b; got cur %0d,%0d char %h attr %h ",
                            "scr %b oor %b"}, n_results, want.crow, want.ccol, want.cchar,
                            want.cattr, want.scr, want.oor, got.crow, got.ccol, got.cchar,
                            got.cattr, got.scr, got.oor));
                end
                rcv_hold = draw_gap(rcv_calm);
                if (rcv_hold != 0) i_out_ready <= 1'b0;
            end
        end else begin
            if (rcv_hold <= 1) i_out_ready <= 1'b1;
            else rcv_hold--;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                ph;
        int                k;
        logic [BYTE_W-1:0] dv;
        logic [BYTE_W-1:0] ev;
        n_fail      = 0;
        n_results   = 0;
        idle_cycles = 0;
        snd_calm    = 1'b0;
        rcv_calm    = 1'b0;
        dflt_attr   = DEFAULT_ATTR_RST;
        err_attr    = ERROR_ATTR_RST;
        cur_pos     = 0;
        wipe_screen();

        // Directed opening: field extremes, every operation and the corner cases.
        pending_cmds.push_back(cmd(FN_READ, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_cmds.push_back(cmd(FN_PUT_CUR, "A", 5'd0, 7'd0, 8'h00));
        pending_cmds.push_back(cmd(FN_PUT_CUR, 8'hFF, 5'd31, 7'd127, 8'hFF));
        pending_cmds.push_back(cmd(FN_PUT_CUR, 8'h00, 5'd0, 7'd0, 8'h01));
        pending_cmds.push_back(cmd(FN_PUT_CUR, CH_BACKSPACE, 5'd0, 7'd0, 8'h5A));
        pending_cmds.push_back(cmd(FN_PUT_CUR, CH_NEWLINE, 5'd0, 7'd0, 8'h00));
        pending_cmds.push_back(cmd(FN_BKSP, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_cmds.push_back(cmd(FN_CLEAR, 8'hFF, 5'd31, 7'd127, 8'hFF));
        pending_cmds.push_back(cmd(FN_BKSP, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_cmds.push_back(cmd(FN_PUT_AT, "Z", 5'(ROWS - 1), 7'(COLS - 1), 8'h3C));
        pending_cmds.push_back(cmd(FN_PUT_AT, CH_NEWLINE, 5'(ROWS - 1), 7'd5, 8'h00));
        pending_cmds.push_back(cmd(FN_PUT_AT, "q", 5'd0, 7'd0, 8'h80));
        pending_cmds.push_back(cmd(FN_PUT_AT, "r", 5'(ROWS), 7'd0, 8'h11));
        pending_cmds.push_back(cmd(FN_PUT_AT, "s", 5'd31, 7'd127, 8'h22));
        pending_cmds.push_back(cmd(FN_PUT_AT, "t", 5'd0, 7'(COLS), 8'h33));
        pending_cmds.push_back(cmd(FN_READ, 8'h00, 5'(ROWS - 1), 7'd127, 8'h00));
        pending_cmds.push_back(cmd(FN_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'h00));
        pending_cmds.push_back(cmd(FN_READ, 8'h00, 5'd0, 7'd0, 8'h00));
        pending_cmds.push_back(cmd(FN_RSVD5, 8'hFF, 5'd3, 7'd3, 8'hFF));
        pending_cmds.push_back(cmd(FN_RSVD6, 8'h41, 5'd31, 7'd127, 8'h00));
        pending_cmds.push_back(cmd(FN_RSVD7, 8'h00, 5'd0, 7'd0, 8'h07));
        pending_cmds.push_back(cmd(FN_PUT_AT, CH_BACKSPACE, 5'd10, 7'd40, 8'h00));
        pending_cmds.push_back(cmd(FN_READ, 8'h00, 5'd10, 7'd40, 8'h00));
        pending_cmds.push_back(cmd(FN_PUT_AT, "x", 5'(ROWS - 1), 7'(COLS - 2), 8'h00));
        pending_cmds.push_back(cmd(FN_PUT_CUR, "y", 5'd0, 7'd0, 8'h9A));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                // Let the block finish any sweep before the attribute registers change.
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge i_clk);
                case (ph)
                    1:       begin dv = 8'h00;            ev = 8'hFF;            end
                    2:       begin dv = 8'hFF;            ev = 8'h00;            end
                    4:       begin dv = DEFAULT_ATTR_RST; ev = BYTE_W'($urandom); end
                    default: begin dv = BYTE_W'($urandom); ev = BYTE_W'($urandom); end
                endcase
                cfg_write(REG_DEFAULT_ATTR, dv);
                cfg_write(REG_ERROR_ATTR, ev);
            end
            for (k = 0; k < RAND_PER_PHASE; k++) pending_cmds.push_back(rand_cmd());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_views.size() != 0) log_failure("predicted results left unmatched");
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
